### rtl/cslx_pkg.sv
package cslx_pkg;

  // default coordinate width, signed fixed point
  localparam int COORD_WIDTH_DEF = 24;

endpackage

### rtl/circle_segment_line_intersection.sv
// channel | signals                                              | transfer when
// --------+------------------------------------------------------+---------------------
// in      | center_x/y, radius_sq, seg_start_x/y, seg_end_x/y    | in_valid & in_ready
// out     | found, first_x/y, second_x/y, clipped                | out_valid & out_ready
//
// one query enters per cycle while the output is not stalled
// the pipeline depth comes mostly from the square root (one root bit per stage) and the four
// coordinate dividers (one quotient bit per stage)
// rst clears the valid bits only; the data path needs no reset
// a stall on the output freezes every stage at once, nothing is dropped or repeated
module circle_segment_line_intersection
  import cslx_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic [2*COORD_WIDTH-1:0]      radius_sq,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic signed [COORD_WIDTH-1:0] first_x,
  output logic signed [COORD_WIDTH-1:0] first_y,
  output logic signed [COORD_WIDTH-1:0] second_x,
  output logic signed [COORD_WIDTH-1:0] second_y,
  output logic                          clipped
);

  localparam int W   = COORD_WIDTH;
  localparam int K   = W + 1;      // difference width, half width of the products
  localparam int RW  = 2 * K;      // product / root width
  localparam int DW  = 4 * K;      // discriminant width
  localparam int PW  = 3 * K + 1;  // numerator * delta width
  localparam int NQ  = K + 1;      // quotient bits
  localparam int LS  = NQ + 5;     // stages after the numerator stage
  localparam int NST = 6 + RW + 1 + LS;

  localparam logic signed [W+2:0] VMAX = signed'((W+3)'({(W-1){1'b1}}));
  localparam logic signed [W+2:0] VMIN = -VMAX - (W+3)'(1);
  localparam logic [NQ-1:0]       QCAP = {1'b1, {K{1'b0}}};

  logic           en;
  logic [NST-1:0] vld;

  // global advance: the whole pipe moves unless the output holds a stalled result
  assign en        = !vld[NST-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // stage 1: differences
  logic signed [K-1:0] s1_dx, s1_dy, s1_ox, s1_oy;
  logic signed [W-1:0] s1_sx, s1_sy;
  logic [2*W-1:0]      s1_rsq;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx  <= K'(seg_end_x) - K'(seg_start_x);
      s1_dy  <= K'(seg_end_y) - K'(seg_start_y);
      s1_ox  <= K'(seg_start_x) - K'(center_x);
      s1_oy  <= K'(seg_start_y) - K'(center_y);
      s1_sx  <= seg_start_x;
      s1_sy  <= seg_start_y;
      s1_rsq <= radius_sq;
    end
  end

  // stage 2: small products
  logic signed [RW-1:0] s2_dxdx, s2_dydy, s2_dxox, s2_dyoy, s2_oxox, s2_oyoy;
  logic signed [K-1:0]  s2_dx, s2_dy;
  logic signed [W-1:0]  s2_sx, s2_sy;
  logic [2*W-1:0]       s2_rsq;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dxdx <= s1_dx * s1_dx;
      s2_dydy <= s1_dy * s1_dy;
      s2_dxox <= s1_dx * s1_ox;
      s2_dyoy <= s1_dy * s1_oy;
      s2_oxox <= s1_ox * s1_ox;
      s2_oyoy <= s1_oy * s1_oy;
      s2_dx   <= s1_dx;
      s2_dy   <= s1_dy;
      s2_sx   <= s1_sx;
      s2_sy   <= s1_sy;
      s2_rsq  <= s1_rsq;
    end
  end

  // stage 3: quadratic coefficients as sign and magnitude
  logic signed [RW:0] s3_h_c, s3_c_c;
  logic [RW-1:0]      s3_a, s3_hmag, s3_cmag;
  logic               s3_hneg, s3_cneg;
  logic signed [K-1:0] s3_dx, s3_dy;
  logic signed [W-1:0] s3_sx, s3_sy;

  always_comb begin
    s3_h_c = (RW+1)'(s2_dxox) + (RW+1)'(s2_dyoy);
    s3_c_c = (RW+1)'(s2_oxox) + (RW+1)'(s2_oyoy) - signed'((RW+1)'(s2_rsq));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_a    <= RW'(s2_dxdx + s2_dydy);
      s3_hneg <= s3_h_c[RW];
      s3_hmag <= RW'(s3_h_c[RW] ? -s3_h_c : s3_h_c);
      s3_cneg <= s3_c_c[RW];
      s3_cmag <= RW'(s3_c_c[RW] ? -s3_c_c : s3_c_c);
      s3_dx   <= s2_dx;
      s3_dy   <= s2_dy;
      s3_sx   <= s2_sx;
      s3_sy   <= s2_sy;
    end
  end

  // stage 4: partial products of H*H and A*C
  logic [RW-1:0] s4_hll, s4_hlh, s4_hhh, s4_all, s4_alh, s4_ahl, s4_ahh;
  logic [RW-1:0] s4_a, s4_hmag;
  logic          s4_hneg, s4_cneg;
  logic signed [K-1:0] s4_dx, s4_dy;
  logic signed [W-1:0] s4_sx, s4_sy;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_hll  <= s3_hmag[K-1:0] * s3_hmag[K-1:0];
      s4_hlh  <= s3_hmag[K-1:0] * s3_hmag[RW-1:K];
      s4_hhh  <= s3_hmag[RW-1:K] * s3_hmag[RW-1:K];
      s4_all  <= s3_a[K-1:0] * s3_cmag[K-1:0];
      s4_alh  <= s3_a[K-1:0] * s3_cmag[RW-1:K];
      s4_ahl  <= s3_a[RW-1:K] * s3_cmag[K-1:0];
      s4_ahh  <= s3_a[RW-1:K] * s3_cmag[RW-1:K];
      s4_a    <= s3_a;
      s4_hmag <= s3_hmag;
      s4_hneg <= s3_hneg;
      s4_cneg <= s3_cneg;
      s4_dx   <= s3_dx;
      s4_dy   <= s3_dy;
      s4_sx   <= s3_sx;
      s4_sy   <= s3_sy;
    end
  end

  // stage 5: sum the partial products
  logic [DW-1:0] s5_hsq, s5_ac;
  logic [RW-1:0] s5_a, s5_hmag;
  logic          s5_hneg, s5_cneg;
  logic signed [K-1:0] s5_dx, s5_dy;
  logic signed [W-1:0] s5_sx, s5_sy;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_hsq  <= (DW'(s4_hhh) << RW) + (DW'(s4_hlh) << (K + 1)) + DW'(s4_hll);
      s5_ac   <= (DW'(s4_ahh) << RW) + ((DW'(s4_alh) + DW'(s4_ahl)) << K) + DW'(s4_all);
      s5_a    <= s4_a;
      s5_hmag <= s4_hmag;
      s5_hneg <= s4_hneg;
      s5_cneg <= s4_cneg;
      s5_dx   <= s4_dx;
      s5_dy   <= s4_dy;
      s5_sx   <= s4_sx;
      s5_sy   <= s4_sy;
    end
  end

  // root pipeline arrays, entry 0 is stage 6
  logic [DW-1:0]       sq_rem  [0:RW];
  logic [RW-1:0]       sq_root [0:RW];
  logic [RW-1:0]       sq_a    [0:RW];
  logic [RW-1:0]       sq_hmag [0:RW];
  logic                sq_hneg [0:RW];
  logic                sq_hit  [0:RW];
  logic signed [K-1:0] sq_dx   [0:RW];
  logic signed [K-1:0] sq_dy   [0:RW];
  logic signed [W-1:0] sq_sx   [0:RW];
  logic signed [W-1:0] sq_sy   [0:RW];

  // stage 6: discriminant and the found decision
  logic [DW:0] s6_d;
  logic        s6_hit;

  always_comb begin
    s6_d   = s5_cneg ? ((DW+1)'(s5_hsq) + (DW+1)'(s5_ac))
                     : ((DW+1)'(s5_hsq) - (DW+1)'(s5_ac));
    s6_hit = (s5_a != '0) && !s6_d[DW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= s6_hit ? s6_d[DW-1:0] : '0;
      sq_root[0] <= '0;
      sq_a[0]    <= s5_a;
      sq_hmag[0] <= s5_hmag;
      sq_hneg[0] <= s5_hneg;
      sq_hit[0]  <= s6_hit;
      sq_dx[0]   <= s5_dx;
      sq_dy[0]   <= s5_dy;
      sq_sx[0]   <= s5_sx;
      sq_sy[0]   <= s5_sy;
    end
  end

  // integer square root, one root bit per stage, remainder kept as D - root^2
  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    localparam int J = RW - 1 - i;
    logic [DW-1:0] trial;

    assign trial = (DW'(sq_root[i]) << (J + 1)) | (DW'(1) << (2 * J));

    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_rem[i] >= trial) begin
          sq_rem[i+1]  <= sq_rem[i] - trial;
          sq_root[i+1] <= sq_root[i] | (RW'(1) << J);
        end else begin
          sq_rem[i+1]  <= sq_rem[i];
          sq_root[i+1] <= sq_root[i];
        end
        sq_a[i+1]    <= sq_a[i];
        sq_hmag[i+1] <= sq_hmag[i];
        sq_hneg[i+1] <= sq_hneg[i];
        sq_hit[i+1]  <= sq_hit[i];
        sq_dx[i+1]   <= sq_dx[i];
        sq_dy[i+1]   <= sq_dy[i];
        sq_sx[i+1]   <= sq_sx[i];
        sq_sy[i+1]   <= sq_sy[i];
      end
    end
  end

  // common arrays after the root, entry 0 is the numerator stage
  logic [RW-1:0] ln_a   [0:LS-2];
  logic          ln_hit [0:LS];

  // numerators -H - s and -H + s as sign and magnitude
  logic signed [RW+1:0] q1_nh, q1_n1, q1_n2;
  logic [RW:0]          q1_nmag [0:1];
  logic                 q1_nneg [0:1];
  logic signed [K-1:0]  q1_dx, q1_dy;
  logic signed [W-1:0]  q1_sx, q1_sy;

  always_comb begin
    q1_nh = sq_hneg[RW] ? signed'((RW+2)'(sq_hmag[RW])) : -signed'((RW+2)'(sq_hmag[RW]));
    q1_n1 = q1_nh - signed'((RW+2)'(sq_root[RW]));
    q1_n2 = q1_nh + signed'((RW+2)'(sq_root[RW]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_nneg[0] <= q1_n1[RW+1];
      q1_nmag[0] <= (RW+1)'(q1_n1[RW+1] ? -q1_n1 : q1_n1);
      q1_nneg[1] <= q1_n2[RW+1];
      q1_nmag[1] <= (RW+1)'(q1_n2[RW+1] ? -q1_n2 : q1_n2);
      q1_dx      <= sq_dx[RW];
      q1_dy      <= sq_dy[RW];
      q1_sx      <= sq_sx[RW];
      q1_sy      <= sq_sy[RW];
      ln_a[0]    <= sq_a[RW];
      ln_hit[0]  <= sq_hit[RW];
    end
  end

  // shared values walk alongside the lanes
  for (genvar i = 0; i < LS; i++) begin : g_common
    always_ff @(posedge clk) begin
      if (en) begin
        ln_hit[i+1] <= ln_hit[i];
      end
    end
    if (i < LS - 2) begin : g_a
      always_ff @(posedge clk) begin
        if (en) begin
          ln_a[i+1] <= ln_a[i];
        end
      end
    end
  end

  logic signed [W-1:0] lane_coord [0:3];
  logic                lane_clip  [0:3];

  // four coordinate lanes: first x, first y, second x, second y
  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam int NI = l / 2;
    localparam bit YL = (l % 2) == 1;

    logic signed [K-1:0] d_c;
    logic [K-1:0]        dmag_c;
    logic signed [W-1:0] start_c;

    // multiply stage
    logic [RW-1:0]       m1_lo;
    logic [RW:0]         m1_hi;
    logic                m1_pneg;
    logic signed [W-1:0] m1_start;
    // sum stage
    logic [PW-1:0]       m2_p;
    logic                m2_pneg;
    logic signed [W-1:0] m2_start;
    // divider, entry 0 is the overflow check
    logic [PW-1:0]       dv_rem   [0:NQ];
    logic [NQ-1:0]       dv_q     [0:NQ];
    logic                dv_ovf   [0:NQ];
    logic                dv_pneg  [0:NQ];
    logic signed [W-1:0] dv_start [0:NQ];
    // rounding stage
    logic [NQ:0]         rd_qr;
    logic [NQ-1:0]       rd_q;
    logic                rd_pneg;
    logic signed [W-1:0] rd_start;
    // final stage
    logic signed [W+2:0] fn_v;
    logic signed [W-1:0] fn_coord;
    logic                fn_clip;

    assign d_c     = YL ? q1_dy : q1_dx;
    assign start_c = YL ? q1_sy : q1_sx;
    assign dmag_c  = K'(d_c[K-1] ? -d_c : d_c);

    always_ff @(posedge clk) begin
      if (en) begin
        m1_lo    <= q1_nmag[NI][K-1:0] * dmag_c;
        m1_hi    <= q1_nmag[NI][RW:K] * dmag_c;
        m1_pneg  <= q1_nneg[NI] ^ d_c[K-1];
        m1_start <= start_c;
        m2_p     <= (PW'(m1_hi) << K) + PW'(m1_lo);
        m2_pneg  <= m1_pneg;
        m2_start <= m1_start;
        // quotient at or above 2^(K+1) is beyond the cap
        dv_ovf[0]   <= m2_p >= (PW'(ln_a[2]) << NQ);
        dv_rem[0]   <= m2_p;
        dv_q[0]     <= '0;
        dv_pneg[0]  <= m2_pneg;
        dv_start[0] <= m2_start;
      end
    end

    // restoring division, one quotient bit per stage
    for (genvar t = 0; t < NQ; t++) begin : g_div
      localparam int B = NQ - 1 - t;
      logic [PW-1:0] dsub;

      assign dsub = PW'(ln_a[3+t]) << B;

      always_ff @(posedge clk) begin
        if (en) begin
          if (!dv_ovf[t] && dv_rem[t] >= dsub) begin
            dv_rem[t+1] <= dv_rem[t] - dsub;
            dv_q[t+1]   <= dv_q[t] | (NQ'(1) << B);
          end else begin
            dv_rem[t+1] <= dv_rem[t];
            dv_q[t+1]   <= dv_q[t];
          end
          dv_ovf[t+1]   <= dv_ovf[t];
          dv_pneg[t+1]  <= dv_pneg[t];
          dv_start[t+1] <= dv_start[t];
        end
      end
    end

    // round half away from zero on the magnitude, then cap
    always_comb begin
      rd_qr = (NQ+1)'(dv_q[NQ])
            + (NQ+1)'((PW'(dv_rem[NQ]) << 1) >= PW'(ln_a[LS-2]));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rd_q     <= (dv_ovf[NQ] || rd_qr > (NQ+1)'(QCAP)) ? QCAP : rd_qr[NQ-1:0];
        rd_pneg  <= dv_pneg[NQ];
        rd_start <= dv_start[NQ];
      end
    end

    // offset from the start point and saturate; coordinates are zero when there is no intersection
    assign fn_v = rd_pneg ? ((W+3)'(rd_start) - signed'((W+3)'(rd_q)))
                          : ((W+3)'(rd_start) + signed'((W+3)'(rd_q)));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!ln_hit[LS-1]) begin
          fn_coord <= '0;
          fn_clip  <= 1'b0;
        end else if (fn_v > VMAX) begin
          fn_coord <= VMAX[W-1:0];
          fn_clip  <= 1'b1;
        end else if (fn_v < VMIN) begin
          fn_coord <= VMIN[W-1:0];
          fn_clip  <= 1'b1;
        end else begin
          fn_coord <= fn_v[W-1:0];
          fn_clip  <= 1'b0;
        end
      end
    end

    assign lane_coord[l] = fn_coord;
    assign lane_clip[l]  = fn_clip;
  end

  // result fields
  assign found    = ln_hit[LS];
  assign first_x  = lane_coord[0];
  assign first_y  = lane_coord[1];
  assign second_x = lane_coord[2];
  assign second_y = lane_coord[3];
  assign clipped  = lane_clip[0] | lane_clip[1] | lane_clip[2] | lane_clip[3];

endmodule
